### design/rks_pkg.sv
// Shared types, constants and the keyword matcher step for the response keyword spotter.
package rks_pkg;

  // Command codes of a request.
  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Characters with a fixed role.
  localparam logic [7:0] FILL_CHAR = 8'h26;  // '&'
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_C    = 8'h43;
  localparam logic [7:0] CHAR_J    = 8'h4a;
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_G    = 8'h47;

  // Match position: zero is idle, every keyword owns a run of positions.
  localparam int unsigned NUM_KW = 4;
  localparam int unsigned KW_MAX = 6;
  localparam logic [4:0]  ST_IDLE = 5'd0;

  localparam logic [7:0] KW_TEXT [NUM_KW][KW_MAX] = '{
    '{8'h65, 8'h72, 8'h72, 8'h6f, 8'h72, 8'h00},  // error
    '{8'h72, 8'h65, 8'h73, 8'h75, 8'h6c, 8'h74},  // result
    '{CHAR_D, CHAR_S, CHAR_C, 8'h00, 8'h00, 8'h00},
    '{CHAR_J, CHAR_P, CHAR_G, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [2:0] KW_LEN  [NUM_KW] = '{3'd5, 3'd6, 3'd3, 3'd3};
  localparam logic [4:0] KW_BASE [NUM_KW] = '{5'd1, 5'd6, 5'd12, 5'd15};
  localparam logic [4:0] KW_TERM [NUM_KW] = '{5'd5, 5'd11, 5'd14, 5'd17};

  // Keyword completed by a byte.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ERROR  = 3'd1,
    EV_RESULT = 3'd2,
    EV_DSC    = 3'd3,
    EV_JPG    = 3'd4
  } kw_event_e;

  // Request payload.
  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
    logic [6:0] read_index;
  } rks_in_t;

  // Result payload.
  typedef struct packed {
    logic [2:0] keyword_event;
    logic       result_seen;
    logic       name_complete;
    logic [7:0] name_length;
    logic [7:0] read_char;
    logic       byte_dropped;
  } rks_out_t;

  // Classified operation handed from the front to the back.
  typedef struct packed {
    rks_out_t   res;
    logic       mem_we;
    logic       mem_re;
    logic [7:0] wdata;
  } rks_op_t;

  // Outcome of one matcher pass.
  typedef struct packed {
    logic [4:0] st;
    logic       iw;
    logic       again;
  } pass_t;

  // One matcher pass over a byte; again is set when the byte must be checked once more.
  function automatic pass_t match_pass(input logic [4:0] st, input logic iw,
                                       input logic [7:0] b);
    pass_t r;
    logic  done;
    r.st    = st;
    r.iw    = iw;
    r.again = 1'b0;
    done    = 1'b0;
    for (int k = 0; k < NUM_KW; k++) begin
      if (!done && !iw && b == KW_TEXT[k][0]) begin
        r.st = KW_BASE[k];
        r.iw = 1'b1;
        done = 1'b1;
      end
      for (int p = 1; p < KW_MAX; p++) begin
        if (!done && p < int'(KW_LEN[k]) && st == 5'(int'(KW_BASE[k]) + p - 1)) begin
          if (b == KW_TEXT[k][p]) begin
            r.st = 5'(int'(KW_BASE[k]) + p);
            if (p == int'(KW_LEN[k]) - 1) begin
              r.iw = 1'b0;
            end
          end else begin
            r.st    = ST_IDLE;
            r.iw    = 1'b0;
            r.again = 1'b1;
          end
          done = 1'b1;
        end
      end
    end
    if (!done) begin
      r.st = ST_IDLE;
    end
    return r;
  endfunction

endpackage

### design/rks_front.sv
// Front part: keyword matching, capture bookkeeping and classification of each request.
module rks_front import rks_pkg::*; #(
  parameter int unsigned NAME_DEPTH = 128,
  localparam int unsigned AW = $clog2(NAME_DEPTH),
  localparam int unsigned LW = $clog2(NAME_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  rks_in_t       req_i,
  output rks_op_t       op_o,
  output logic [AW-1:0] addr_o
);

  localparam int unsigned CW = (LW > 7) ? LW : 7;
  localparam int unsigned OW = (LW > 8) ? LW : 8;

  logic [4:0]    st_q, st_d;
  logic          iw_q, iw_d;
  logic          cap_q, cap_d;
  logic          sfx_q, sfx_d;
  logic [LW-1:0] len_q, len_d;

  pass_t         p1, p2;
  kw_event_e     ev;
  logic [CW-1:0] idx_ext, len_cmp;
  logic [OW-1:0] len_out;

  // Matcher passes and the event of the current byte.
  always_comb begin
    p1 = match_pass(st_q, iw_q, req_i.rx_byte);
    p2 = p1.again ? match_pass(p1.st, p1.iw, req_i.rx_byte) : p1;
    ev = EV_NONE;
    for (int k = 0; k < NUM_KW; k++) begin
      if (p2.st == KW_TERM[k]) begin
        ev = kw_event_e'(3'(k + 1));
      end
    end
  end

  assign idx_ext = CW'(req_i.read_index);
  assign len_cmp = CW'(len_q);

  // Next state and the operation for the back part.
  always_comb begin
    st_d   = st_q;
    iw_d   = iw_q;
    cap_d  = cap_q;
    sfx_d  = sfx_q;
    len_d  = len_q;
    op_o   = '0;
    addr_o = len_q[AW-1:0];

    if (req_i.command == CMD_READ) begin
      addr_o = idx_ext[AW-1:0];
      if (idx_ext < len_cmp) begin
        // The first three characters always hold the DSC prefix.
        if (req_i.read_index < 7'd3) begin
          case (req_i.read_index[1:0])
            2'd0:    op_o.res.read_char = CHAR_D;
            2'd1:    op_o.res.read_char = CHAR_S;
            default: op_o.res.read_char = CHAR_C;
          endcase
        end else begin
          op_o.mem_re = 1'b1;
        end
      end else begin
        op_o.res.read_char = FILL_CHAR;
      end
    end else begin
      st_d = p2.st;
      iw_d = p2.iw;
      op_o.res.keyword_event = ev;
      op_o.res.result_seen   = (ev == EV_RESULT);
      op_o.wdata             = req_i.rx_byte;

      // Append the byte to an open capture, or drop it when the store is full.
      if (cap_q && !sfx_q) begin
        if (len_q < LW'(NAME_DEPTH)) begin
          op_o.mem_we = 1'b1;
          len_d       = len_q + LW'(1);
        end else begin
          op_o.res.byte_dropped = 1'b1;
        end
      end

      // A DSC restarts the capture; a JPG closes it.
      if (ev == EV_DSC) begin
        len_d = LW'(3);
        cap_d = 1'b1;
        sfx_d = 1'b0;
      end
      if (ev == EV_JPG) begin
        op_o.res.name_complete = cap_q;
        sfx_d = 1'b1;
        cap_d = 1'b0;
      end
    end
    len_out              = OW'(len_d);
    op_o.res.name_length = len_out[7:0];
  end

  // Matcher and capture state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_IDLE;
      iw_q  <= 1'b0;
      cap_q <= 1'b0;
      sfx_q <= 1'b0;
      len_q <= '0;
    end else if (accept_i) begin
      st_q  <= st_d;
      iw_q  <= iw_d;
      cap_q <= cap_d;
      sfx_q <= sfx_d;
      len_q <= len_d;
    end
  end

`ifndef SYNTHESIS
  // The capture length never passes the store depth.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(NAME_DEPTH))
    else $error("capture length beyond store depth");

  // A DSC leaves exactly the three prefix characters.
  a_dsc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && req_i.command == CMD_FEED && ev == EV_DSC) |=> (len_q == LW'(3)))
    else $error("DSC did not restart the capture");

  // A partial match always has a match position.
  a_word_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iw_q |-> (st_q != ST_IDLE))
    else $error("partial match without a position");

  // An open capture has not yet seen its suffix.
  a_cap_sfx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cap_q |-> !sfx_q)
    else $error("capture open after suffix");
`endif

endmodule

### design/rks_queue.sv
// Two-entry queue that decouples the front part from the back part.
module rks_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wdata_i,
  input  logic         pop_i,
  output logic [W-1:0] rdata_o,
  output logic         full_o,
  output logic         empty_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PW     = $clog2(QDEPTH);
  localparam int unsigned NW     = $clog2(QDEPTH + 1);

  logic [W-1:0]  slot_q [QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [NW-1:0] cnt_q;

  assign full_o  = (cnt_q == NW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = slot_q[rptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### design/rks_back.sv
// Back part: name store writes and reads, and the result register.
module rks_back import rks_pkg::*; #(
  parameter int unsigned NAME_DEPTH = 128,
  localparam int unsigned AW = $clog2(NAME_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  rks_op_t       op_i,
  input  logic [AW-1:0] addr_i,
  output logic          q_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rks_out_t      rsp_o
);

  logic [7:0] store_q [NAME_DEPTH];
  logic [7:0] rdata_q;
  rks_out_t   res_q;
  logic       sel_q;
  logic       valid_q;
  logic       advance;

  // Take the next operation when the result register is free or being emptied.
  assign advance = !q_empty_i && (!valid_q || pop_i);
  assign q_pop_o = advance;
  assign empty_o = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  // Name store and result register, updated in request order.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (op_i.mem_we) begin
        store_q[addr_i] <= op_i.wdata;
      end
      if (op_i.mem_re) begin
        rdata_q <= store_q[addr_i];
      end
      res_q <= op_i.res;
      sel_q <= op_i.mem_re;
    end
  end

  // Stored characters come from the registered read data.
  always_comb begin
    rsp_o = res_q;
    if (sel_q) begin
      rsp_o.read_char = rdata_q;
    end
  end

endmodule

### design/response_keyword_spotter_unit.sv
// Top level of the response keyword spotter: front, decoupling queue and back.
//
// Requests enter on req_i when push is high and full is low. A feed request
// passes one received byte through the keyword matcher (error, result, DSC,
// JPG) and the name capture; a read request asks for one captured character.
// Every request gives exactly one result on rsp_o, in request order.
// A result is available while empty is low and is taken when pop is high.
//
// A request is written into the front-to-back queue when it is accepted and
// moves on into the result register, together with the registered name store
// read, once that register is free or being emptied. Throughput is one request
// per cycle while full is low.
//
// Reset clears the matcher, the capture length, the queue and the valid flag of
// the result register; the name store needs no clearing, since only written
// positions are ever read.
// When the receiver stops popping, the result register holds its result,
// the two-entry queue fills, and full rises until pop resumes.
module response_keyword_spotter_unit import rks_pkg::*; #(
  parameter int unsigned NAME_DEPTH = 128
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  rks_in_t  req_i,
  output logic     empty,
  input  logic     pop,
  output rks_out_t rsp_o
);

  localparam int unsigned AW = $clog2(NAME_DEPTH);
  localparam int unsigned QW = $bits(rks_op_t) + AW;

  logic          accept;
  rks_op_t       f_op, q_op;
  logic [AW-1:0] f_addr, q_addr;
  logic [QW-1:0] q_rdata;
  logic          q_full, q_empty, q_pop;

  assign accept = push && !q_full;
  assign full   = q_full;

  // Matching and classification.
  rks_front #(.NAME_DEPTH(NAME_DEPTH)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .op_o     (f_op),
    .addr_o   (f_addr)
  );

  // Decoupling queue.
  rks_queue #(.W(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i ({f_op, f_addr}),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {q_op, q_addr} = q_rdata;

  // Name store and results.
  rks_back #(.NAME_DEPTH(NAME_DEPTH)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .op_i      (q_op),
    .addr_i    (q_addr),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .rsp_o     (rsp_o)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the response keyword spotter: directed table, random streams.
module testbench;
  import rks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NAME_DEPTH   = 128;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          N_DIRECTED   = 31;
  localparam int          LONG_HOLD    = 80;
  localparam int          CYCLE_LIMIT  = 500000;

  // Lower-case keyword letters used by the directed table.
  localparam logic [7:0] CH_E  = 8'h65;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_O  = 8'h6f;
  localparam logic [7:0] CH_LS = 8'h73;
  localparam logic [7:0] CH_U  = 8'h75;
  localparam logic [7:0] CH_L  = 8'h6c;
  localparam logic [7:0] CH_T  = 8'h74;

  // Event reported when each keyword reaches its last character.
  localparam kw_event_e KW_EVENT [NUM_KW] = '{EV_ERROR, EV_RESULT, EV_DSC, EV_JPG};

  // One request with an optional hand-written result.
  typedef struct packed {
    rks_in_t  req;
    logic     chk;
    rks_out_t fixed;
  } req_entry_t;

  localparam rks_out_t NO_RES = '0;

  // Directed requests; rows with chk set carry the result read straight off the spec.
  localparam req_entry_t DIRECTED [N_DIRECTED] = '{
    '{'{CMD_READ, 8'h5a, 7'd0},   1'b1, '{EV_NONE, 1'b0, 1'b0, 8'd0, FILL_CHAR, 1'b0}},
    '{'{CMD_READ, 8'ha5, 7'd127}, 1'b1, '{EV_NONE, 1'b0, 1'b0, 8'd0, FILL_CHAR, 1'b0}},
    '{'{CMD_FEED, CH_E, 7'h55},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_R, 7'h2a},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_R, 7'h00},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_O, 7'h7f},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_R, 7'h11},   1'b1, '{EV_ERROR, 1'b0, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{CMD_FEED, CH_R, 7'h22},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_E, 7'h33},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_LS, 7'h44},  1'b0, NO_RES},
    '{'{CMD_FEED, CH_U, 7'h55},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_L, 7'h66},   1'b0, NO_RES},
    '{'{CMD_FEED, CH_T, 7'h77},   1'b1, '{EV_RESULT, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0}},
    '{'{CMD_FEED, CH_E, 7'h01},   1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_D, 7'h02}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_S, 7'h04}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_C, 7'h08}, 1'b1, '{EV_DSC, 1'b0, 1'b0, 8'd3, 8'd0, 1'b0}},
    '{'{CMD_READ, 8'h0f, 7'd2},   1'b1, '{EV_NONE, 1'b0, 1'b0, 8'd3, CHAR_C, 1'b0}},
    '{'{CMD_READ, 8'hf0, 7'd3},   1'b1, '{EV_NONE, 1'b0, 1'b0, 8'd3, FILL_CHAR, 1'b0}},
    '{'{CMD_FEED, CHAR_D, 7'h10}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_S, 7'h20}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_C, 7'h40}, 1'b0, NO_RES},
    '{'{CMD_FEED, 8'hff, 7'h7f},  1'b0, NO_RES},
    '{'{CMD_FEED, 8'h00, 7'h00},  1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_J, 7'h3c}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_P, 7'h43}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_G, 7'h19}, 1'b1, '{EV_JPG, 1'b0, 1'b1, 8'd8, 8'd0, 1'b0}},
    '{'{CMD_READ, 8'h96, 7'd7},   1'b1, '{EV_NONE, 1'b0, 1'b0, 8'd8, CHAR_G, 1'b0}},
    '{'{CMD_FEED, CHAR_J, 7'h61}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_P, 7'h0e}, 1'b0, NO_RES},
    '{'{CMD_FEED, CHAR_G, 7'h70}, 1'b0, NO_RES}
  };

  logic     clk_i;
  logic     rst_ni;
  logic     push;
  logic     full;
  rks_in_t  req_i;
  logic     empty;
  logic     pop;
  rks_out_t rsp_o;

  // Tag of the request currently offered, seen by the monitor at acceptance.
  logic     cur_chk;
  rks_out_t cur_fixed;

  // Shadow state of the spotter.
  logic [4:0]  mstate    = ST_IDLE;
  logic        in_kw     = 1'b0;
  logic        capt_on   = 1'b0;
  logic        tail_seen = 1'b0;
  int unsigned name_len  = 0;
  logic [7:0]  name_mem [NAME_DEPTH];

  req_entry_t stim_q [$];
  rks_out_t   pending_q [$];

  int cycle_cnt      = 0;
  int accepted_cnt   = 0;
  int result_cnt     = 0;
  int mismatch_cnt   = 0;
  int n_feed         = 0;
  int n_read         = 0;
  int n_names        = 0;
  int n_dropped      = 0;
  int n_kw           = 0;
  bit long_hold_done = 1'b0;

  response_keyword_spotter_unit #(
    .NAME_DEPTH(NAME_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push  (push),
    .full  (full),
    .req_i (req_i),
    .empty (empty),
    .pop   (pop),
    .rsp_o (rsp_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    foreach (name_mem[i]) name_mem[i] = FILL_CHAR;
  end

  // One matcher pass; returns 1 when the byte has to be looked at again from idle.
  function automatic bit scan_pass(input logic [7:0] b);
    int base;
    int len;
    for (int k = 0; k < NUM_KW; k++) begin
      base = int'(KW_BASE[k]);
      len  = int'(KW_LEN[k]);
      if (!in_kw && b == KW_TEXT[k][0]) begin
        mstate = 5'(base);
        in_kw  = 1'b1;
        return 1'b0;
      end
      for (int p = 1; p < len; p++) begin
        if (mstate == 5'(base + p - 1)) begin
          if (b == KW_TEXT[k][p]) begin
            mstate = 5'(base + p);
            if (p == len - 1) in_kw = 1'b0;
            return 1'b0;
          end
          mstate = ST_IDLE;
          in_kw  = 1'b0;
          return 1'b1;
        end
      end
    end
    mstate = ST_IDLE;
    return 1'b0;
  endfunction

  // Advance the shadow state by one request and return its result.
  function automatic rks_out_t spot_step(input rks_in_t r);
    rks_out_t o;
    o = '0;
    if (r.command == CMD_READ) begin
      o.read_char = (r.read_index < name_len) ? name_mem[r.read_index] : FILL_CHAR;
    end else begin
      if (scan_pass(r.rx_byte)) void'(scan_pass(r.rx_byte));
      for (int k = 0; k < NUM_KW; k++)
        if (mstate == KW_TERM[k]) o.keyword_event = KW_EVENT[k];
      o.result_seen = (o.keyword_event == EV_RESULT);
      // Append to the name, or drop once the store is full.
      if (capt_on && !tail_seen) begin
        if (name_len < NAME_DEPTH) begin
          name_mem[name_len] = r.rx_byte;
          name_len++;
        end else begin
          o.byte_dropped = 1'b1;
        end
      end
      // A new DSC restarts the name from scratch.
      if (o.keyword_event == EV_DSC) begin
        foreach (name_mem[i]) name_mem[i] = FILL_CHAR;
        name_mem[0] = CHAR_D;
        name_mem[1] = CHAR_S;
        name_mem[2] = CHAR_C;
        name_len    = 3;
        capt_on     = 1'b1;
        tail_seen   = 1'b0;
      end
      if (o.keyword_event == EV_JPG) begin
        o.name_complete = capt_on;
        tail_seen       = 1'b1;
        capt_on         = 1'b0;
      end
    end
    o.name_length = 8'(name_len);
    return o;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic add_feed(input logic [7:0] b);
    req_entry_t e;
    e       = '0;
    e.req   = '{command: CMD_FEED, rx_byte: b, read_index: 7'($urandom)};
    stim_q.push_back(e);
  endtask

  task automatic add_read(input logic [6:0] idx);
    req_entry_t e;
    e       = '0;
    e.req   = '{command: CMD_READ, rx_byte: 8'($urandom), read_index: idx};
    stim_q.push_back(e);
  endtask

  task automatic add_word(input int k);
    for (int p = 0; p < int'(KW_LEN[k]); p++) add_feed(KW_TEXT[k][p]);
  endtask

  // Random streams: whole keywords, broken keywords, reads, long captures and noise.
  task automatic gen_random(input int count);
    int kind;
    int k;
    int n;
    int target;
    target = stim_q.size() + count;
    while (stim_q.size() < target) begin
      kind = $urandom_range(0, 99);
      k    = $urandom_range(0, NUM_KW - 1);
      if (kind < 25) begin
        add_word(k);
      end else if (kind < 40) begin
        n = $urandom_range(1, int'(KW_LEN[k]) - 1);
        for (int p = 0; p < n; p++) add_feed(KW_TEXT[k][p]);
        add_feed(8'($urandom));
      end else if (kind < 62) begin
        if ($urandom_range(0, 1)) add_read(7'($urandom_range(0, 127)));
        else add_read(7'($urandom_range(0, 15)));
      end else if (kind < 64) begin
        // Long capture that may run past the end of the store.
        add_word(2);
        n = $urandom_range(90, 150);
        repeat (n) add_feed(8'($urandom));
        add_read(7'd127);
        add_read(7'($urandom_range(0, 127)));
        add_word(3);
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) add_feed(8'($urandom));
      end
    end
  endtask

  // Offer one request after an idle gap and hold it until it is taken.
  task automatic send_request(input req_entry_t e, input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push      <= 1'b1;
    req_i     <= e.req;
    cur_chk   <= e.chk;
    cur_fixed <= e.fixed;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  // Stop offering until every outstanding result has been taken.
  task automatic wait_all_results();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic check_field(input string fname, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      if (mismatch_cnt < 10)
        $display("Mismatch in result %0d, %s: expected %0h, got %0h",
                 result_cnt, fname, want, got);
      mismatch_cnt++;
    end
  endtask

  // Monitor: predict on each accepted request, check each taken result.
  always @(posedge clk_i) begin
    rks_out_t pred;
    rks_out_t want;
    if (rst_ni) begin
      if (push && !full) begin
        pred = spot_step(req_i);
        pending_q.push_back(cur_chk ? cur_fixed : pred);
        accepted_cnt++;
        if (req_i.command == CMD_READ) n_read++;
        else n_feed++;
        if (pred.keyword_event != EV_NONE) n_kw++;
        if (pred.name_complete) n_names++;
        if (pred.byte_dropped) n_dropped++;
      end
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          if (mismatch_cnt < 10) $display("Result %0d arrived with nothing expected", result_cnt);
          mismatch_cnt++;
        end else begin
          want = pending_q.pop_front();
          check_field("keyword_event", 8'(want.keyword_event), 8'(rsp_o.keyword_event));
          check_field("result_seen", 8'(want.result_seen), 8'(rsp_o.result_seen));
          check_field("name_complete", 8'(want.name_complete), 8'(rsp_o.name_complete));
          check_field("name_length", want.name_length, rsp_o.name_length);
          check_field("read_char", want.read_char, rsp_o.read_char);
          check_field("byte_dropped", 8'(want.byte_dropped), 8'(rsp_o.byte_dropped));
        end
        result_cnt++;
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random pop gaps, long runs of pops, and one long hold-off.
  initial begin : receiver
    int gap;
    pop = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!long_hold_done && accepted_cnt >= N_DIRECTED + 400) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        gap = idle_len();
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      pop <= 1'b1;
      if ($urandom_range(0, 99) < 5) repeat ($urandom_range(40, 100)) @(negedge clk_i);
      else repeat ($urandom_range(1, 24)) @(negedge clk_i);
    end
  end

  // Sender and end of run.
  initial begin : sender
    int gap;
    int burst;
    int half;
    push      = 1'b0;
    req_i     = '0;
    cur_chk   = 1'b0;
    cur_fixed = '0;
    rst_ni    = 1'b0;
    burst     = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table.
    for (int i = 0; i < N_DIRECTED; i++) send_request(DIRECTED[i], idle_len());
    wait_all_results();

    // Random part, with one full drain half way through.
    gen_random(RANDOM_ITEMS);
    half = stim_q.size() / 2;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == half) wait_all_results();
      if (burst > 0) begin
        burst--;
        gap = 0;
      end else begin
        gap = idle_len();
        if ($urandom_range(0, 99) < 3) burst = $urandom_range(20, 60);
      end
      send_request(stim_q[i], gap);
    end
    push <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_q.size());
      mismatch_cnt++;
    end
    $display("Run covered %0d feed and %0d read requests, %0d keywords spotted.",
             n_feed, n_read, n_kw);
    $display("Names completed: %0d, capture bytes dropped on a full store: %0d.",
             n_names, n_dropped);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d failures", mismatch_cnt);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
